// File: sv/fpt_pkg.sv
`default_nettype none
package fpt_pkg;

    localparam int SHARP_W = 24;
    localparam int COUNT_W = 8;
    localparam int PCT_W   = 8;
    localparam int FLOOR_W = 16;
    localparam int FRAC_W  = 8;
    localparam int HIST_DEPTH = 4;
    localparam int FRAMES_W   = 3;

    // Sharpness times 100 needs 7 more bits; a percent times the level needs 8.
    localparam int SCALED_W = SHARP_W + 8;

    localparam logic [SCALED_W-1:0] PCT_SCALE = SCALED_W'(100);
    localparam logic [FRAMES_W-1:0] FRAMES_FULL = FRAMES_W'(HIST_DEPTH);
    localparam logic [SHARP_W-1:0]  SHARP_MAX = {SHARP_W{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_PCT  = 2'd0,
        CFG_EXIT_PCT   = 2'd1,
        CFG_PEAK_FLOOR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               found;
        logic [SHARP_W-1:0] level;
        logic [COUNT_W-1:0] total;
    } t_peak_info;

endpackage
`default_nettype wire

// File: sv/focus_peak_tracker.sv
`default_nettype none
// The input register holds an accepted request until it moves into the result register.
// Throughput: 1 request per cycle while the result register is empty or being taken;
// the input and result registers advance together whenever that holds.
// Reset (i_rst_n low, synchronous): history, counters, peak level and focus state
// clear; entry 90 %, exit 80 %, peak floor 0.
module focus_peak_tracker
    import fpt_pkg::*;
#(
    parameter int MIN_PEAKS = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,  // [23:0] sharpness
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] in_focus, [1] peak_found, [25:2] peak_level, [33:26] peaks_seen, rest zero
    output logic [39:0]                m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PCT_W-1:0]   r_entry_pct;
    logic [PCT_W-1:0]   r_exit_pct;
    logic [FLOOR_W-1:0] r_peak_floor;

    logic               r_in_vld;
    logic [SHARP_W-1:0] r_sharp;
    logic               r_out_vld;
    logic               r_out_focus;
    t_peak_info         r_out_info;

    logic       w_adv;
    logic       w_focus;
    t_peak_info w_info;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_pct  <= PCT_W'(90);
            r_exit_pct   <= PCT_W'(80);
            r_peak_floor <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENTRY_PCT:  r_entry_pct  <= i_cfg_data[PCT_W-1:0];
                CFG_EXIT_PCT:   r_exit_pct   <= i_cfg_data[PCT_W-1:0];
                CFG_PEAK_FLOOR: r_peak_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the input register into the result register when the slot frees up.
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_sharp <= s_axis_tdata;
        end
        if (w_adv) begin
            r_out_focus <= w_focus;
            r_out_info  <= w_info;
        end
    end

    fpt_peak u_peak (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_sharp      (r_sharp),
        .i_peak_floor (r_peak_floor),
        .o_info       (w_info)
    );

    fpt_focus #(
        .MIN_PEAKS (MIN_PEAKS)
    ) u_focus (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_sharp     (r_sharp),
        .i_entry_pct (r_entry_pct),
        .i_exit_pct  (r_exit_pct),
        .i_info      (w_info),
        .o_in_focus  (w_focus)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out_info.total, r_out_info.level,
                            r_out_info.found, r_out_focus};

endmodule
`default_nettype wire

// File: sv/fpt_peak.sv
`default_nettype none
module fpt_peak
    import fpt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic [SHARP_W-1:0] i_sharp,
    input  wire logic [FLOOR_W-1:0] i_peak_floor,
    output t_peak_info              o_info
);

    logic [SHARP_W-1:0]  r_hist [HIST_DEPTH];
    logic [FRAMES_W-1:0] r_frames;
    logic [SHARP_W-1:0]  r_avg;
    logic [COUNT_W-1:0]  r_total;

    logic [FRAMES_W-1:0] n_frames;
    logic [SHARP_W-1:0]  n_avg;
    logic [COUNT_W-1:0]  n_total;
    logic [SHARP_W:0]    w_sum;
    logic [SHARP_W-1:0]  w_floor;
    logic [SHARP_W-1:0]  w_cand;
    logic                w_found;

    // After the shift the candidate sits at slot 2, which is slot 3 today.
    assign w_cand  = r_hist[3];
    assign w_floor = {i_peak_floor, FRAC_W'(0)};
    assign w_sum   = {1'b0, r_avg} + {1'b0, w_cand};

    always_comb begin
        n_frames = (r_frames < FRAMES_FULL) ? r_frames + FRAMES_W'(1) : r_frames;
        w_found  = (n_frames >= FRAMES_FULL) && (r_hist[1] != '0) && (i_sharp != '0)
                   && (r_hist[1] < r_hist[2]) && (r_hist[2] < w_cand)
                   && (w_cand > i_sharp) && (w_cand > w_floor);
        n_avg   = r_avg;
        n_total = r_total;
        if (w_found) begin
            n_avg   = (r_avg == '0) ? w_cand : w_sum[SHARP_W:1];
            n_total = (r_total != COUNT_MAX) ? r_total + COUNT_W'(1) : r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_frames <= '0;
            r_avg    <= '0;
            r_total  <= '0;
        end else if (i_adv) begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HIST_DEPTH-1] <= i_sharp;
            r_frames <= n_frames;
            r_avg    <= n_avg;
            r_total  <= n_total;
        end
    end

    assign o_info.found = w_found;
    assign o_info.level = n_avg;
    assign o_info.total = n_total;

endmodule
`default_nettype wire

// File: sv/fpt_focus.sv
`default_nettype none
module fpt_focus
    import fpt_pkg::*;
#(
    parameter int MIN_PEAKS = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic [SHARP_W-1:0] i_sharp,
    input  wire logic [PCT_W-1:0]   i_entry_pct,
    input  wire logic [PCT_W-1:0]   i_exit_pct,
    input  wire t_peak_info         i_info,
    output logic                    o_in_focus
);

    logic                r_focus;
    logic [SCALED_W-1:0] r_leave_prod;

    logic                n_focus;
    logic [SCALED_W-1:0] n_leave_prod;
    logic [SCALED_W-1:0] w_sharp_x100;
    logic [SCALED_W-1:0] w_sharp1_x100;
    logic [SCALED_W-1:0] w_entry_prod;
    logic [SCALED_W-1:0] w_exit_prod;

    // Compare in scaled form: s > floor(x/100) iff 100*s > x,
    // and s < floor(x/100) iff 100*(s+1) <= x.
    assign w_sharp_x100  = SCALED_W'(i_sharp) * PCT_SCALE;
    assign w_sharp1_x100 = (SCALED_W'(i_sharp) + SCALED_W'(1)) * PCT_SCALE;
    assign w_entry_prod  = SCALED_W'(i_entry_pct) * SCALED_W'(i_info.level);
    assign w_exit_prod   = SCALED_W'(i_exit_pct) * SCALED_W'(i_info.level);

    always_comb begin
        n_focus      = r_focus;
        n_leave_prod = r_leave_prod;
        if (!r_focus) begin
            if ((i_info.level != '0) && (w_sharp_x100 > w_entry_prod)
                    && (i_info.total > COUNT_W'(MIN_PEAKS))) begin
                n_focus      = 1'b1;
                n_leave_prod = w_exit_prod;
            end
        end else begin
            // Exit level saturates at full scale, so full-scale sharpness never drops.
            if ((i_sharp != SHARP_MAX) && (w_sharp1_x100 <= r_leave_prod)) begin
                n_focus = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus      <= 1'b0;
            r_leave_prod <= '0;
        end else if (i_adv) begin
            r_focus      <= n_focus;
            r_leave_prod <= n_leave_prod;
        end
    end

    assign o_in_focus = n_focus;

endmodule
`default_nettype wire

// File: tb/tb_focus_peak_tracker.sv
`default_nettype none
module tb_focus_peak_tracker;
    import fpt_pkg::*;

    localparam int MIN_PEAKS  = 5;
    localparam int LATENCY    = 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 185;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [5:0]         pad;
        logic [COUNT_W-1:0] peaks_seen;
        logic [SHARP_W-1:0] peak_level;
        logic               peak_found;
        logic               in_focus;
    } t_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SHARP_W-1:0]    s_axis_tdata = '0;   // [23:0] sharpness
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] in_focus, [1] peak_found, [25:2] peak_level, [33:26] peaks_seen
    logic [39:0]           m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    focus_peak_tracker #(
        .MIN_PEAKS(MIN_PEAKS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Tracker copy: settings and state as they stand after reset
    logic [PCT_W-1:0]                     entry_pct = 8'd90;
    logic [PCT_W-1:0]                     exit_pct = 8'd80;
    logic [FLOOR_W-1:0]                   floor_int = '0;
    logic [HIST_DEPTH-1:0][SHARP_W-1:0]   hist = '0;
    logic [FRAMES_W-1:0]                  frames_cnt = '0;
    logic [SHARP_W-1:0]                   avg_level = '0;
    logic [COUNT_W-1:0]                   peak_cnt = '0;
    logic                                 focus_st = 1'b0;
    logic [SHARP_W-1:0]                   leave_lvl = '0;

    logic [SHARP_W-1:0] pending_sharp[$];
    t_status            predicted_status[$];

    int  mismatches = 0;
    int  frames_sent = 0;
    int  peaks_found = 0;
    int  focus_entries = 0;
    int  reg_writes = 0;
    int  results_taken = 0;
    int  idle_cycles = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  rx_hold = 0;
    bit  no_idle = 1'b0;
    t_status got, want;

    function automatic t_status track_frame(input logic [SHARP_W-1:0] s);
        t_status      st;
        logic [SHARP_W-1:0] p;
        logic [SHARP_W:0]   sum;
        logic [31:0]  enter_lvl;
        logic [31:0]  leave_calc;
        st = '0;
        hist = {s, hist[HIST_DEPTH-1:1]};
        if (frames_cnt < FRAMES_FULL)
            frames_cnt++;
        if (frames_cnt == FRAMES_FULL && hist[0] != '0 && hist[3] != '0) begin
            p = hist[2];
            if (hist[0] < hist[1] && hist[1] < p && p > hist[3] && p > {floor_int, 8'h00}) begin
                if (avg_level == '0) begin
                    avg_level = p;
                end else begin
                    sum = {1'b0, avg_level} + {1'b0, p};
                    avg_level = sum[SHARP_W:1];
                end
                if (peak_cnt != COUNT_MAX)
                    peak_cnt++;
                st.peak_found = 1'b1;
                peaks_found++;
            end
        end
        if (!focus_st) begin
            enter_lvl = (32'(entry_pct) * 32'(avg_level)) / PCT_SCALE;
            if (avg_level != '0 && 32'(s) > enter_lvl && int'(peak_cnt) > MIN_PEAKS) begin
                leave_calc = (32'(exit_pct) * 32'(avg_level)) / PCT_SCALE;
                leave_lvl = (leave_calc > 32'(SHARP_MAX)) ? SHARP_MAX : leave_calc[SHARP_W-1:0];
                focus_st = 1'b1;
                focus_entries++;
            end
        end else if (s < leave_lvl) begin
            focus_st = 1'b0;
        end
        st.in_focus   = focus_st;
        st.peak_level = avg_level;
        st.peaks_seen = peak_cnt;
        return st;
    endfunction

    // Mostly zero, sometimes a short gap, rarely a long stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_status.push_back(track_frame(s_axis_tdata));
                void'(pending_sharp.pop_front());
                frames_sent++;
            end
            // hold the request until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_sharp.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_sharp[0];
                    if (!no_idle)
                        tx_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
            rx_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_status'(m_axis_tdata);
                if (predicted_status.size() == 0) begin
                    if (mismatches < 10)
                        $display("result with nothing expected: focus=%0d found=%0d level=%h peaks=%0d",
                                 got.in_focus, got.peak_found, got.peak_level, got.peaks_seen);
                    mismatches++;
                end else begin
                    want = predicted_status.pop_front();
                    if (got.in_focus !== want.in_focus || got.peak_found !== want.peak_found ||
                        got.peak_level !== want.peak_level ||
                        got.peaks_seen !== want.peaks_seen || got.pad !== want.pad) begin
                        if (mismatches < 10) begin
                            $display("result %0d: expected focus=%0d found=%0d level=%h peaks=%0d pad=%h",
                                     results_taken, want.in_focus, want.peak_found,
                                     want.peak_level, want.peaks_seen, want.pad);
                            $display("    got focus=%0d found=%0d level=%h peaks=%0d pad=%h",
                                     got.in_focus, got.peak_found, got.peak_level,
                                     got.peaks_seen, got.pad);
                        end
                        mismatches++;
                    end
                end
                results_taken++;
                // back up the pipeline while requests keep coming
                if (results_taken == 500 || results_taken == 1200)
                    rx_hold = 250;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!no_idle)
                    rx_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_ENTRY_PCT:  entry_pct = data[PCT_W-1:0];
            CFG_EXIT_PCT:   exit_pct  = data[PCT_W-1:0];
            CFG_PEAK_FLOOR: floor_int = data;
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_sharp.size() != 0 || predicted_status.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Mostly rise-rise-peak runs that the next run's low start turns into a peak,
    // mixed with plateaus near the peak level, raw noise and full-scale or zero values
    task automatic queue_frames(input int count, input int amp);
        int left, r, a, b, c, n;
        left = count;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                c = $urandom_range(amp / 2 + 3, amp);
                a = $urandom_range(1, c / 3);
                b = $urandom_range(a + 1, c - 1);
                pending_sharp.push_back(SHARP_W'(a));
                pending_sharp.push_back(SHARP_W'(b));
                pending_sharp.push_back(SHARP_W'(c));
                left -= 3;
            end else if (r < 85) begin
                n = $urandom_range(1, 4);
                repeat (n) pending_sharp.push_back(SHARP_W'($urandom_range(amp / 2, amp)));
                left -= n;
            end else if (r < 95) begin
                pending_sharp.push_back(SHARP_W'($urandom));
                left--;
            end else begin
                pending_sharp.push_back(r[0] ? SHARP_MAX : '0);
                left--;
            end
        end
    endtask

    initial begin
        int entry_v, exit_v, floor_v, amp;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, six peaks to arm focus, then enter and leave it
        pending_sharp.push_back('0);
        pending_sharp.push_back(SHARP_MAX);
        repeat (6) begin
            pending_sharp.push_back(24'h001000);
            pending_sharp.push_back(24'h002000);
            pending_sharp.push_back(24'h003000);
        end
        pending_sharp.push_back(24'h001000);
        pending_sharp.push_back(24'h003000);
        pending_sharp.push_back(24'h002000);
        pending_sharp.push_back(SHARP_MAX);
        pending_sharp.push_back('0);

        for (int ph = 0; ph < PHASES; ph++) begin
            amp = (1 << $urandom_range(8, 24)) - 1;
            entry_v = $urandom_range(0, 255);
            exit_v  = $urandom_range(0, 255);
            floor_v = $urandom_range(0, amp >> 9);
            no_idle = (ph == 1 || ph == 5);
            case (ph)
                0: begin entry_v = 90;  exit_v = 80;  floor_v = 0;      amp = 24'h3FFF; end
                1: begin entry_v = 0;   exit_v = 0;   floor_v = 0;      amp = 24'hFF;   end
                2: begin entry_v = 255; exit_v = 255; floor_v = 0;      amp = SHARP_MAX; end
                3: begin entry_v = 100; exit_v = 255; floor_v = 16'hFFFF; amp = SHARP_MAX; end
                default: ;
            endcase
            wait_drained();
            if (ph == 0)
                write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
            write_reg(CFG_ENTRY_PCT, {8'($urandom_range(0, 255)), 8'(entry_v)});
            write_reg(CFG_EXIT_PCT, {8'($urandom_range(0, 255)), 8'(exit_v)});
            write_reg(CFG_PEAK_FLOOR, CFG_DATA_W'(floor_v));
            queue_frames(PHASE_ITEMS, amp);
        end
        wait_drained();

        $display("Covered %0d frames over %0d setting phases with %0d register writes.",
                 frames_sent, PHASES + 1, reg_writes);
        $display("Saw %0d peaks (counter ended at %0d) and %0d entries into focus.",
                 peaks_found, peak_cnt, focus_entries);
        if (mismatches == 0 && predicted_status.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
sv/fpt_pkg.sv
sv/fpt_peak.sv
sv/fpt_focus.sv
sv/focus_peak_tracker.sv
tb/tb_focus_peak_tracker.sv
